// ===== src/text_console_writer_defines.svh =====
// Assertion macros shared by the console writer RTL.
// Included by text_console_writer.sv and tcw_screen.sv; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, off while reset is asserted.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/tcw_pkg.sv =====
// Shared constants, screen request codes and interface structs for the console writer.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;      // power of two
    localparam int CELLS    = COLUMNS * ROWS;

    localparam int ADDR_W   = 11;     // cell index / cursor width
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int TAB_BITS = $clog2(TAB_STOP);
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CODE_W   = 8;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

    localparam logic [CODE_W-1:0] CH_TAB = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CODE_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CODE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CODE_W-1:0] CH_ESC = 8'h1B;

    typedef logic [2:0] t_scr_op;
    localparam t_scr_op OP_NONE   = 3'd0;
    localparam t_scr_op OP_WRITE  = 3'd1;
    localparam t_scr_op OP_READ   = 3'd2;
    localparam t_scr_op OP_CLEAR  = 3'd3;
    localparam t_scr_op OP_SCROLL = 3'd4;

    typedef struct packed {
        t_scr_op             op;
        logic [ADDR_W-1:0]   addr;
        logic [CELL_W-1:0]   wdata;
    } t_scr_req;

    typedef struct packed {
        logic                busy;
        logic [CELL_W-1:0]   rdata;
    } t_scr_rsp;

endpackage

// ===== src/tcw_screen.sv =====
// Screen cell memory with its clear and scroll sweep sequencer.
// Depends on tcw_pkg and text_console_writer_defines.svh.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module tcw_screen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_scr_req i_req,
    output tcw_pkg::t_scr_rsp o_rsp
);
    import tcw_pkg::*;

    localparam logic [1:0] SS_IDLE   = 2'd0;
    localparam logic [1:0] SS_CLEAR  = 2'd1;
    localparam logic [1:0] SS_SCROLL = 2'd2;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pend, n_pend;     // copy write due this cycle
    logic [ADDR_W-1:0] r_dst, n_dst;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pend    = 1'b0;
        n_dst     = r_dst;
        mem_we    = 1'b0;
        mem_waddr = i_req.addr;
        mem_wdata = i_req.wdata;
        mem_raddr = '0;
        case (r_state)
            SS_IDLE: begin
                case (i_req.op)
                    OP_WRITE: mem_we = 1'b1;
                    OP_READ:  mem_raddr = i_req.addr;
                    OP_CLEAR: begin
                        n_state = SS_CLEAR;
                        n_cnt   = '0;
                    end
                    OP_SCROLL: begin
                        n_state = SS_SCROLL;
                        n_cnt   = CNT_W'(COLUMNS);
                    end
                    default: ;
                endcase
            end
            SS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[ADDR_W-1:0];
                mem_wdata = '0;
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_state = SS_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            SS_SCROLL: begin
                // read row below, write it one row up in the following cycle
                mem_we    = r_pend;
                mem_waddr = r_dst;
                mem_wdata = r_rdata;
                if (r_cnt != CNT_W'(CELLS)) begin
                    mem_raddr = r_cnt[ADDR_W-1:0];
                    n_pend    = 1'b1;
                    n_dst     = ADDR_W'(r_cnt - CNT_W'(COLUMNS));
                    n_cnt     = r_cnt + 1'b1;
                end else begin
                    n_state = SS_CLEAR;           // blank the new bottom row
                    n_cnt   = CNT_W'(CELLS - COLUMNS);
                end
            end
            default: n_state = SS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_CLEAR;                  // power-on clear pass
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst <= n_dst;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_rsp.busy  = (r_state != SS_IDLE);
    assign o_rsp.rdata = r_rdata;

    `TCW_ASSERT(a_waddr_range, i_clk, i_rst_n, mem_we |-> (mem_waddr < ADDR_W'(CELLS)), "screen write off the screen")
    `TCW_ASSERT(a_pend_scroll, i_clk, i_rst_n, r_pend |-> (r_state == SS_SCROLL), "copy write outside scroll")
    `TCW_ASSERT(a_scroll_to_clear, i_clk, i_rst_n, ((r_state == SS_SCROLL) && (r_cnt == CNT_W'(CELLS))) |=> ((r_state == SS_CLEAR) && (r_cnt == CNT_W'(CELLS - COLUMNS))), "scroll did not blank bottom row")

endmodule

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: stream ports, APB attribute register,
// cursor tracking and the item sequencer. Depends on tcw_pkg, tcw_screen and
// text_console_writer_defines.svh.
//
// Input stream (s_axis_*): one word per item; tuser[0] = func (0 write char,
//   1 read cell), tdata = char_code [7:0], cell_addr [18:8].
// Output stream (m_axis_*): one word per item, in order; tdata = cursor_pos
//   [10:0], cell_data [26:11] (zero for character writes).
// APB: attribute byte at address 0, put above each written character; write it
//   only while the block is idle.
// One item in flight at a time, s_axis_tready low while it works; the result
// word shows up in the same cycle the next word can be taken. Plain characters,
// newline, return, tab and escape finish straight from the execute state; a
// cell read waits on the registered read port; form feed waits for the clear
// sweep (one cell a cycle); a cursor running off the end waits for the scroll
// copy (one cell a cycle), then for the blanking of the bottom row.
// Reset: cursor to 0, attribute to 0x07, then a clear pass over all CELLS
// (2000) cells of the screen memory; no word is accepted until it ends.
// Stalls: the result waits in an output register and the next word is still
// accepted; an item finishing against a full register holds its result.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [18:8] cell_addr, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] func
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [10:0] cursor_pos, [26:11] cell_data, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcw_pkg::*;

    localparam int AX_W = ADDR_W + 1;          // cursor plus overrun bit
    localparam int CX_W = COL_W + 1;

    localparam logic [AX_W-1:0] CELLS_X = AX_W'(CELLS);
    localparam logic [AX_W-1:0] COLS_X  = AX_W'(COLUMNS);
    localparam logic [CX_W-1:0] COLS_C  = CX_W'(COLUMNS);

    localparam logic [0:0] REG_ATTR = 1'b0;    // word index of attribute

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_RDWAIT  = 3'd2;
    localparam logic [2:0] ST_SCRL    = 3'd3;
    localparam logic [2:0] ST_SCRWAIT = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // ---------------------------------------------------------------
    // Attribute register (APB)
    // ---------------------------------------------------------------
    logic [ATTR_W-1:0] r_attr;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2:2] == REG_ATTR);
    assign prdata = (paddr[2:2] == REG_ATTR) ? {{(32 - ATTR_W){1'b0}}, r_attr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= DEFAULT_ATTR;
        end else if (cfg_we) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Item registers and sequencer state
    // ---------------------------------------------------------------
    logic [2:0]        r_state, n_state;
    logic              r_func;
    logic [CODE_W-1:0] r_code;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rd_ok;                // read address lies on screen
    logic [ADDR_W-1:0] r_cur, n_cur;           // linear cursor
    logic [COL_W-1:0]  r_col, n_col;           // cursor column, kept alongside
    logic [CELL_W-1:0] r_res_data, n_res_data; // held result while output stalls

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_cur;
    logic [CELL_W-1:0] r_out_data;

    logic              in_acc;
    logic              out_free;
    logic              load_out;
    logic [CELL_W-1:0] load_data;
    logic              finish;
    logic [CELL_W-1:0] fin_data;

    tcw_pkg::t_scr_req scr_req;
    tcw_pkg::t_scr_rsp scr_rsp;

    assign s_axis_tready = (r_state == ST_IDLE) && !scr_rsp.busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // ---------------------------------------------------------------
    // Cursor arithmetic for a written character
    // ---------------------------------------------------------------
    logic [AX_W-1:0] cur_ext;
    logic [AX_W-1:0] tab_cur;
    logic [AX_W-1:0] tab_delta;
    logic [CX_W-1:0] tab_sum;
    logic [COL_W-1:0] tab_col;
    logic [AX_W-1:0] x_cur;      // cursor after the character, may overrun
    logic [AX_W-1:0] x_sub;      // same, one row up
    logic [COL_W-1:0] x_col;
    logic            x_ff;
    logic            x_put;

    assign cur_ext   = AX_W'(r_cur);
    assign tab_cur   = ((cur_ext >> TAB_BITS) + 1'b1) << TAB_BITS;
    assign tab_delta = tab_cur - cur_ext;
    assign tab_sum   = CX_W'(r_col) + tab_delta[CX_W-1:0];
    assign tab_col   = (tab_sum >= COLS_C) ? COL_W'(tab_sum - COLS_C) : tab_sum[COL_W-1:0];
    assign x_sub     = x_cur - COLS_X;

    always_comb begin
        x_cur = cur_ext;
        x_col = r_col;
        x_ff  = 1'b0;
        x_put = 1'b0;
        case (r_code)
            CH_LF, CH_CR: begin
                x_cur = cur_ext - AX_W'(r_col) + COLS_X;
                x_col = '0;
            end
            CH_TAB: begin
                x_cur = tab_cur;
                x_col = tab_col;
            end
            CH_FF: begin
                x_cur = '0;
                x_col = '0;
                x_ff  = 1'b1;
            end
            CH_ESC: ;                          // swallowed
            default: begin
                x_put = 1'b1;
                x_cur = cur_ext + 1'b1;
                x_col = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_cur         = r_cur;
        n_col         = r_col;
        n_res_data    = r_res_data;
        scr_req.op    = OP_NONE;
        scr_req.addr  = r_cur;
        scr_req.wdata = {r_attr, r_code};
        finish        = 1'b0;
        fin_data      = '0;
        load_out      = 1'b0;
        load_data     = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_func) begin
                    if (r_rd_ok) begin
                        scr_req.op   = OP_READ;
                        scr_req.addr = r_addr;
                    end
                    n_state = ST_RDWAIT;
                end else if (x_ff) begin
                    scr_req.op = OP_CLEAR;
                    n_cur      = '0;
                    n_col      = '0;
                    n_state    = ST_SCRWAIT;
                end else begin
                    if (x_put) begin
                        scr_req.op = OP_WRITE;
                    end
                    n_col = x_col;
                    if (x_cur >= CELLS_X) begin
                        n_cur   = x_sub[ADDR_W-1:0];
                        n_state = ST_SCRL;
                    end else begin
                        n_cur  = x_cur[ADDR_W-1:0];
                        finish = 1'b1;
                    end
                end
            end
            ST_RDWAIT: begin
                finish   = 1'b1;
                fin_data = r_rd_ok ? scr_rsp.rdata : '0;
            end
            ST_SCRL: begin
                scr_req.op = OP_SCROLL;
                n_state    = ST_SCRWAIT;
            end
            ST_SCRWAIT: begin
                if (!scr_rsp.busy) begin
                    finish = 1'b1;
                end
            end
            ST_DONE: begin
                finish   = 1'b1;
                fin_data = r_res_data;
            end
            default: n_state = ST_IDLE;
        endcase

        if (finish) begin
            if (out_free) begin
                load_out  = 1'b1;
                load_data = fin_data;
                n_state   = ST_IDLE;
            end else begin
                n_res_data = fin_data;
                n_state    = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_col   <= n_col;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func  <= s_axis_tuser[0];
            r_code  <= s_axis_tdata[CODE_W-1:0];
            r_addr  <= s_axis_tdata[CODE_W +: ADDR_W];
            r_rd_ok <= (s_axis_tdata[CODE_W +: ADDR_W] < ADDR_W'(CELLS));
        end
        r_res_data <= n_res_data;
        if (load_out) begin
            r_out_cur  <= n_cur;
            r_out_data <= load_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(32 - ADDR_W - CELL_W){1'b0}}, r_out_data, r_out_cur};

    // ---------------------------------------------------------------
    // Screen memory and sweep unit
    // ---------------------------------------------------------------
    tcw_screen u_screen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scr_req),
        .o_rsp   (scr_rsp)
    );

    `TCW_ASSERT(a_req_when_idle, i_clk, i_rst_n, (scr_req.op != OP_NONE) |-> !scr_rsp.busy,
                "screen request while sweep busy")
    `TCW_ASSERT(a_no_overwrite, i_clk, i_rst_n, load_out |-> (!r_out_valid || m_axis_tready),
                "result overwrote a waiting word")
    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n, r_out_valid |-> (r_out_cur < ADDR_W'(CELLS)),
                "reported cursor off the screen")

endmodule

// ===== verif/text_console_writer_tb.sv =====
// Self-checking bench for text_console_writer: streams characters and cell reads,
// predicts cursor and cell contents from its own screen copy, drives APB attribute writes.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    // register map: one attribute byte at index 0, index 1 is unmapped
    localparam int REG_ATTR   = 0;
    localparam int REG_UNUSED = 1;

    localparam int HOLD_CYCLES = 600;        // long sink stall to back up the block
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 275;        // 6 x 275 random words
    localparam int SETTLE      = 16;         // idle cycles after the last result
    localparam int MAX_REPORTS = 200;
    // worst case: every word a full-screen scroll, x4 margin
    localparam longint CYCLE_LIMIT = 64'd16_000_000;

    typedef enum logic [0:0] {
        FN_WRITE_CHAR = 1'b0,
        FN_READ_CELL  = 1'b1
    } t_func;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } t_console_result;

    // Screen copy plus cursor; turns every accepted word into the result it must produce.
    class t_screen_tracker;
        logic [CELL_W-1:0] cells [CELLS];
        int unsigned       cursor;
        logic [ATTR_W-1:0] attr;
        t_console_result   due_results [$];
        int unsigned       errors, n_words, n_results, n_reads, n_clears, n_scrolls;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor = 0;
            attr   = DEFAULT_ATTR;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
        endfunction

        // drop 'rows' lines off the top, blank the bottom, pull the cursor up
        function void scroll_up(int unsigned rows);
            int unsigned shift;
            if (rows > ROWS) rows = ROWS;
            shift = rows * COLUMNS;
            for (int i = 0; i < CELLS; i++)
                cells[i] = (i + shift < CELLS) ? cells[i + shift] : '0;
            cursor = (cursor >= shift) ? cursor - shift : 0;
            n_scrolls++;
        endfunction

        function void put_char(logic [CODE_W-1:0] code);
            case (code)
                CH_LF, CH_CR: cursor = (cursor / COLUMNS + 1) * COLUMNS;
                CH_TAB:       cursor = (cursor / TAB_STOP + 1) * TAB_STOP;
                CH_FF: begin
                    foreach (cells[i]) cells[i] = '0;
                    cursor = 0;
                    n_clears++;
                end
                CH_ESC: ;
                default: begin
                    if (cursor < CELLS) cells[cursor] = {attr, code};
                    cursor++;
                end
            endcase
            if (cursor >= CELLS) scroll_up((cursor - CELLS) / COLUMNS + 1);
        endfunction

        function void take_item(t_func fn, logic [CODE_W-1:0] code,
                                logic [ADDR_W-1:0] addr);
            t_console_result r;
            r.cell_data = '0;
            if (fn == FN_WRITE_CHAR) begin
                put_char(code);
            end else begin
                n_reads++;
                if (addr < CELLS) r.cell_data = cells[addr];
            end
            r.cursor_pos = cursor[ADDR_W-1:0];
            due_results.push_back(r);
            n_words++;
        endfunction

        function void match_result(logic [ADDR_W-1:0] pos, logic [CELL_W-1:0] data);
            t_console_result want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result word: cursor %0d cell %h", pos, data));
                return;
            end
            want = due_results.pop_front();
            n_results++;
            if (pos !== want.cursor_pos)
                report($sformatf("cursor_pos: expected %0d, got %0d",
                                 want.cursor_pos, pos));
            if (data !== want.cell_data)
                report($sformatf("cell_data: expected %h, got %h", want.cell_data, data));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [7:0] char_code, [18:8] cell_addr, [23:19] zero
    logic [0:0]  s_axis_tuser;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [10:0] cursor_pos, [26:11] cell_data, [31:27] zero
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    t_screen_tracker trk = new();

    longint      cycle_count = 0;
    int unsigned words_sent  = 0;
    int unsigned attr_writes = 0;
    bit          calm        = 1'b0;   // no gaps on either side while set
    bit          hold_now    = 1'b0;   // one-shot request for the long sink stall
    bit          hold_done   = 1'b0;

    text_console_writer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog; only a hung block gets here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, trk.due_results.size());
            $display("text_console_writer_tb NOT OK");
            $finish;
        end
    end

    // Handshake monitor. Values read right after the edge are the ones the
    // block sampled, so no ordering issue with its own flops.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                trk.take_item(t_func'(s_axis_tuser[0]), s_axis_tdata[7:0],
                              s_axis_tdata[18:8]);
            if (m_axis_tvalid && m_axis_tready)
                trk.match_result(m_axis_tdata[10:0], m_axis_tdata[26:11]);
        end
    end

    // Sink: random stalls ~13%, none in the calm window, plus one long hold-off
    // counted here while the source keeps pushing.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_now) begin
                hold_now = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= (!calm && $urandom_range(99) < 13) ? 1'b0 : 1'b1;
        end
    end

    // Offer one word and wait for it to be taken. Returns on the accepting edge
    // with tvalid still high so back-to-back words need no second assignment.
    task automatic push_item(t_func fn, logic [CODE_W-1:0] code, logic [ADDR_W-1:0] addr);
        calm = (words_sent >= 1000 && words_sent < 1300);
        if (!hold_done && words_sent >= 600) begin
            hold_done = 1'b1;
            hold_now  = 1'b1;
        end
        while (!calm && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {5'b0, addr, code};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic put(logic [CODE_W-1:0] code);
        push_item(FN_WRITE_CHAR, code, ADDR_W'($urandom));
    endtask

    task automatic peek(logic [ADDR_W-1:0] addr);
        push_item(FN_READ_CELL, CODE_W'($urandom), addr);
    endtask

    // Stop offering and let every due result come back; block is then idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (trk.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write (setup + access), then read the attribute back and compare.
    task automatic write_reg(int idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_ATTR) begin
            trk.attr = val[ATTR_W-1:0];
            attr_writes++;
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= 3'(4 * REG_ATTR);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[ATTR_W-1:0] !== trk.attr)
            trk.report($sformatf("attribute readback: expected %h, got %h",
                                 trk.attr, prdata[ATTR_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic made of bursts: text runs, reads near the cursor, tab
    // and newline runs, rare clears, broken escape sequences and raw noise.
    task automatic random_phase(int unsigned n);
        int unsigned target;
        int unsigned kind, len;
        int          a;
        target = words_sent + n;
        while (words_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                // text run; long ones wrap and run off the bottom
                len = $urandom_range(1, 90);
                repeat (len) begin
                    if ($urandom_range(9) == 0) put(CODE_W'($urandom_range(255)));
                    else                        put(CODE_W'($urandom_range(8'h20, 8'h7E)));
                end
                if ($urandom_range(1)) put($urandom_range(1) ? CH_LF : CH_CR);
            end else if (kind < 58) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: begin
                            // just behind the cursor, where text was written
                            a = int'(trk.cursor) - int'($urandom_range(0, 100));
                            peek(ADDR_W'((a < 0) ? 0 : a));
                        end
                        9:       peek(ADDR_W'($urandom_range(CELLS, 2**ADDR_W - 1)));
                        default: peek(ADDR_W'($urandom_range(CELLS - 1)));
                    endcase
                end
            end else if (kind < 68) begin
                // tab run; on the last row this overruns and scrolls
                len = $urandom_range(1, 12);
                repeat (len) put(CH_TAB);
            end else if (kind < 78) begin
                len = $urandom_range(1, 4);
                repeat (len) put($urandom_range(1) ? CH_LF : CH_CR);
            end else if (kind < 81) begin
                put(CH_FF);
            end else if (kind < 90) begin
                // escape followed by what would be a CSI sequence, maybe cut short
                put(CH_ESC);
                put(8'h5B);                                  // '['
                len = $urandom_range(0, 3);
                repeat (len) put(CODE_W'($urandom_range(8'h30, 8'h39)));
                if ($urandom_range(1)) put($urandom_range(1) ? 8'h6D : 8'h48);  // 'm' / 'H'
            end else begin
                len = $urandom_range(1, 8);
                repeat (len)
                    push_item(t_func'($urandom_range(1)), CODE_W'($urandom),
                              ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [ATTR_W-1:0] attr_plan [PHASES];
        attr_plan[0] = 8'h00;
        attr_plan[1] = 8'hFF;
        attr_plan[2] = 8'h80;
        attr_plan[3] = 8'h01;
        attr_plan[4] = ATTR_W'($urandom);
        attr_plan[5] = ATTR_W'($urandom);

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset attribute. push_item waits out the
        // post-reset screen clear by itself.
        put(CH_FF);                 // clear an already blank screen, home
        put(8'h41);                 // 'A' at cell 0
        put(8'h00);                 // lowest code stored like any other
        put(8'hFF);                 // highest code, must not sign-extend
        put(CH_ESC);                // swallowed, cursor stays at 3
        put(CH_TAB);                // to 8
        put(8'h7F);
        put(CH_CR);                 // to 80
        put(8'h7A);
        put(CH_LF);                 // to 160
        peek(11'd0);
        peek(11'd1);
        push_item(FN_READ_CELL, 8'hFF, 11'd2);   // code bits ignored on reads
        peek(11'd3);                // skipped by the tab, still blank
        peek(11'd8);
        peek(11'd80);
        peek(ADDR_W'(CELLS - 1));   // last on-screen cell
        peek(ADDR_W'(CELLS));       // first address off the screen
        peek(11'h7FF);              // highest address
        put(CH_FF);
        peek(11'd0);                // clear really blanked it

        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p == 0) write_reg(REG_UNUSED, 32'hFFFF_FFFF);   // unmapped, no effect
            write_reg(REG_ATTR, {24'($urandom), attr_plan[p]});
            random_phase(PHASE_WORDS);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (trk.due_results.size() != 0)
            trk.report($sformatf("%0d results never arrived", trk.due_results.size()));

        $display("covered %0d words (%0d cell reads), %0d results checked",
                 trk.n_words, trk.n_reads, trk.n_results);
        $display("  %0d screen clears, %0d scrolls, %0d attribute settings, %0d errors",
                 trk.n_clears, trk.n_scrolls, attr_writes, trk.errors);
        if (trk.errors == 0) begin
            $display("text_console_writer_tb OK");
        end else begin
            $display("text_console_writer_tb NOT OK");
        end
        $finish;
    end

endmodule
